/* design/rpls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// route part locate and spans package
// field widths, stream packing offsets, request and result codes
// ----------------------------------------------------------------------------
package rpls_pkg;

   localparam int KIND_W  = 2;
   localparam int ID_W    = 16;
   localparam int SLOT_W  = 16;
   localparam int LEN_W   = 24;
   localparam int VID_W   = 32;
   localparam int DIST_W  = 32;
   localparam int SPEED_W = 24;
   localparam int START_W = 32;
   // signed working width for distance compares, covers start plus length and rear
   localparam int EXT_W   = 34;

   localparam int DEF_MAX_PARTS = 32;

   // request tdata: segment_id, segment_slot, part_len, vehicle_id,
   // front_distance, vehicle_length, vehicle_speed
   localparam int REQ_SID_LO   = 0;
   localparam int REQ_SLOT_LO  = REQ_SID_LO + ID_W;
   localparam int REQ_PLEN_LO  = REQ_SLOT_LO + SLOT_W;
   localparam int REQ_VID_LO   = REQ_PLEN_LO + LEN_W;
   localparam int REQ_FRONT_LO = REQ_VID_LO + VID_W;
   localparam int REQ_VLEN_LO  = REQ_FRONT_LO + DIST_W;
   localparam int REQ_SPEED_LO = REQ_VLEN_LO + LEN_W;
   localparam int REQ_TDATA_W  = REQ_SPEED_LO + SPEED_W;
   // request tuser: kind, first_part
   localparam int REQ_TUSER_W  = KIND_W + 1;

   // result tdata: owner_id, found_segment_id, found_segment_slot,
   // from_offset, to_offset, span_speed
   localparam int RSP_TDATA_W  = VID_W + ID_W + SLOT_W + 3 * LEN_W;
   localparam int RSP_TUSER_W  = KIND_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_LOCATE = 2'd1,
      KIND_SPANS  = 2'd2,
      KIND_NONE   = 2'd3
   } req_kind_type;

   localparam logic [KIND_W-1:0] RES_LOCATION = 2'd0;
   localparam logic [KIND_W-1:0] RES_SPAN     = 2'd1;
   localparam logic [KIND_W-1:0] RES_EMPTY    = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]    seg_id;
      logic [SLOT_W-1:0]  seg_slot;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
   } part_entry_type;

endpackage
`default_nettype wire

/* design/route_part_locate_and_spans.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// route part locate and spans
// route part table in one memory, with locate and occupied-span queries
// ----------------------------------------------------------------------------
// The route is held as an ordered table of contiguous parts in a single
// part memory (segment id, segment slot, start, length), one entry per part,
// read through a registered port. A load request appends a part;
// first_part restarts the table at entry zero. A locate or span request is
// accepted while idle and then walks the table from entry zero, one entry
// per cycle while its results are taken, a rate set by the single read
// port of the part memory;
// a span query stops early once it passes the front of the vehicle, a locate
// at the first part that ends beyond the front. Results leave through an
// output register, so a new request is taken while the last result still
// waits; a stalled result holds the walk on its entry. Loads beyond
// MAX_PARTS entries are dropped. The table needs no clearing after reset:
// only entries below the part count are ever read.
module route_part_locate_and_spans #(
   parameter int MAX_PARTS = rpls_pkg::DEF_MAX_PARTS
) (
   input  wire                             clock,
   input  wire                             reset,
   // request channel
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // [15:0] segment_id, [31:16] segment_slot, [55:32] part_len,
   // [87:56] vehicle_id, [119:88] front_distance, [143:120] vehicle_length,
   // [167:144] vehicle_speed
   input  wire [rpls_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] kind, [2] first_part
   input  wire [rpls_pkg::REQ_TUSER_W-1:0] req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // [31:0] owner_id, [47:32] found_segment_id, [63:48] found_segment_slot,
   // [87:64] from_offset, [111:88] to_offset, [135:112] span_speed
   output logic [rpls_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] result_kind
   output logic [rpls_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int CNT_W = $clog2(MAX_PARTS + 1);

   localparam int ID_W    = rpls_pkg::ID_W;
   localparam int SLOT_W  = rpls_pkg::SLOT_W;
   localparam int LEN_W   = rpls_pkg::LEN_W;
   localparam int VID_W   = rpls_pkg::VID_W;
   localparam int DIST_W  = rpls_pkg::DIST_W;
   localparam int SPEED_W = rpls_pkg::SPEED_W;
   localparam int START_W = rpls_pkg::START_W;
   localparam int EXT_W   = rpls_pkg::EXT_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // ---------------------------------------------------------------------
   // request field unpacking
   // ---------------------------------------------------------------------
   logic [rpls_pkg::KIND_W-1:0] req_kind;
   logic                        req_first;
   logic [ID_W-1:0]             req_sid;
   logic [SLOT_W-1:0]           req_slot;
   logic [LEN_W-1:0]            req_plen;
   logic [VID_W-1:0]            req_vid;
   logic [DIST_W-1:0]           req_front;
   logic [LEN_W-1:0]            req_vlen;
   logic [SPEED_W-1:0]          req_speed;

   assign req_kind  = req_tuser[rpls_pkg::KIND_W-1:0];
   assign req_first = req_tuser[rpls_pkg::KIND_W];
   assign req_sid   = req_tdata[rpls_pkg::REQ_SID_LO +: ID_W];
   assign req_slot  = req_tdata[rpls_pkg::REQ_SLOT_LO +: SLOT_W];
   assign req_plen  = req_tdata[rpls_pkg::REQ_PLEN_LO +: LEN_W];
   assign req_vid   = req_tdata[rpls_pkg::REQ_VID_LO +: VID_W];
   assign req_front = req_tdata[rpls_pkg::REQ_FRONT_LO +: DIST_W];
   assign req_vlen  = req_tdata[rpls_pkg::REQ_VLEN_LO +: LEN_W];
   assign req_speed = req_tdata[rpls_pkg::REQ_SPEED_LO +: SPEED_W];

   // ---------------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [START_W-1:0]  running_ff, running_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   // query held for the walk
   logic [rpls_pkg::KIND_W-1:0] qkind_ff;
   logic signed [EXT_W-1:0]     qfront_ff;
   logic signed [EXT_W-1:0]     qrear_ff;
   logic [VID_W-1:0]            qvid_ff;
   logic [SPEED_W-1:0]          qspeed_ff;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rpls_pkg::KIND_W-1:0] rsp_kind_ff;
   logic [VID_W-1:0]            rsp_owner_ff;
   logic [ID_W-1:0]             rsp_sid_ff;
   logic [SLOT_W-1:0]           rsp_slot_ff;
   logic [LEN_W-1:0]            rsp_from_ff;
   logic [LEN_W-1:0]            rsp_to_ff;
   logic [SPEED_W-1:0]          rsp_speed_ff;
   logic                        rsp_last_ff;

   logic req_fire;
   logic req_query;
   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_query  = (req_kind == rpls_pkg::KIND_LOCATE) ||
                       (req_kind == rpls_pkg::KIND_SPANS);
   // output register can take a new result this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------------
   // part memory: one write port for loads, one registered read port for
   // the walk, addressed by the next walk index
   // ---------------------------------------------------------------------
   rpls_pkg::part_entry_type part_mem [MAX_PARTS];
   rpls_pkg::part_entry_type rd_q;
   rpls_pkg::part_entry_type wr_entry;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;

   always_comb begin
      wr_entry.seg_id   = req_sid;
      wr_entry.seg_slot = req_slot;
      wr_entry.length   = req_plen;
      if (req_first) begin
         wr_entry.start = '0;
         wr_addr        = '0;
      end else begin
         wr_entry.start = running_ff;
         wr_addr        = count_ff[IDX_W-1:0];
      end
      // a full table drops the load unless it restarts the route
      wr_en = req_fire && (req_kind == rpls_pkg::KIND_LOAD) &&
              (req_first || (count_ff < CNT_W'(MAX_PARTS)));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         part_mem[wr_addr] <= wr_entry;
      end
      rd_q <= part_mem[idx_in];
   end

   // ---------------------------------------------------------------------
   // walk evaluation on the entry at idx_ff
   // ---------------------------------------------------------------------
   logic signed [EXT_W-1:0] e_start;
   logic signed [EXT_W-1:0] e_len;
   logic signed [EXT_W-1:0] e_end;
   logic signed [EXT_W-1:0] front_rel;
   logic signed [EXT_W-1:0] rear_rel;
   logic                    at_last;
   logic                    front_hit;   // front lies before the end of the part
   logic                    rear_hit;    // rear lies before the end of the part
   logic                    want_emit;
   logic                    want_done;
   logic                    want_step;
   logic                    emit_go;
   logic [rpls_pkg::KIND_W-1:0] e_kind;
   logic [VID_W-1:0]        e_owner;
   logic [ID_W-1:0]         e_sid;
   logic [SLOT_W-1:0]       e_slot;
   logic [LEN_W-1:0]        e_from;
   logic [LEN_W-1:0]        e_to;
   logic [SPEED_W-1:0]      e_speed;
   logic                    e_last;

   always_comb begin
      e_start   = $signed({{(EXT_W-START_W){1'b0}}, rd_q.start});
      e_len     = $signed({{(EXT_W-LEN_W){1'b0}}, rd_q.length});
      e_end     = e_start + e_len;
      front_rel = qfront_ff - e_start;
      rear_rel  = qrear_ff - e_start;
      at_last   = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));
      front_hit = (qfront_ff < e_end);
      rear_hit  = (qrear_ff < e_end);

      want_emit = 1'b0;
      want_done = 1'b0;
      want_step = 1'b0;
      e_kind    = rpls_pkg::RES_LOCATION;
      e_owner   = '0;
      e_sid     = rd_q.seg_id;
      e_slot    = rd_q.seg_slot;
      e_from    = '0;
      e_to      = '0;
      e_speed   = '0;
      e_last    = 1'b1;

      if (count_ff == '0) begin
         // empty table: locate reports it, spans give nothing
         want_done = 1'b1;
         e_sid     = '0;
         e_slot    = '0;
         if (qkind_ff == rpls_pkg::KIND_LOCATE) begin
            want_emit = 1'b1;
            e_kind    = rpls_pkg::RES_EMPTY;
         end
      end else if (qkind_ff == rpls_pkg::KIND_LOCATE) begin
         if (front_hit || at_last) begin
            want_emit = 1'b1;
            want_done = 1'b1;
            if (!front_hit) begin
               // beyond the route: last part at full length
               e_from = rd_q.length;
            end else if (front_rel < 0) begin
               // before the route: clamp to the start of the first part
               e_from = '0;
            end else begin
               e_from = front_rel[LEN_W-1:0];
            end
         end else begin
            want_step = 1'b1;
         end
      end else begin
         // span walk: skip parts wholly behind the rear, then emit every
         // part up to the one holding the front
         e_kind  = rpls_pkg::RES_SPAN;
         e_owner = qvid_ff;
         e_speed = qspeed_ff;
         e_from  = (rear_rel < 0) ? '0 : rear_rel[LEN_W-1:0];
         e_to    = front_hit ? front_rel[LEN_W-1:0] : rd_q.length;
         // parts are contiguous, so the next one starts at this one's end
         e_last  = at_last || front_hit;
         if (!rear_hit) begin
            want_done = at_last;
            want_step = !at_last;
         end else if (qfront_ff >= e_start) begin
            want_emit = 1'b1;
            want_done = e_last;
            want_step = !e_last;
         end else begin
            want_done = 1'b1;
         end
      end
   end

   // a result that cannot be placed holds the walk on this entry
   assign emit_go = (state_ff == ST_SCAN) && want_emit && out_free;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      running_in = running_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_fire && req_query) begin
               state_in = ST_SCAN;
            end
            if (wr_en) begin
               if (req_first) begin
                  count_in   = CNT_W'(1);
                  running_in = START_W'(req_plen);
               end else begin
                  count_in   = count_ff + CNT_W'(1);
                  running_in = running_ff + START_W'(req_plen);
               end
            end
         end
         ST_SCAN: begin
            if (!want_emit || out_free) begin
               if (want_done) begin
                  state_in = ST_IDLE;
                  idx_in   = '0;
               end else if (want_step) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // query capture and result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire && req_query) begin
         qkind_ff  <= req_kind;
         qfront_ff <= $signed({{(EXT_W-DIST_W){req_front[DIST_W-1]}}, req_front});
         qrear_ff  <= $signed({{(EXT_W-DIST_W){req_front[DIST_W-1]}}, req_front}) -
                      $signed({{(EXT_W-LEN_W){1'b0}}, req_vlen});
         qvid_ff   <= req_vid;
         qspeed_ff <= req_speed;
      end
      if (emit_go) begin
         rsp_kind_ff  <= e_kind;
         rsp_owner_ff <= e_owner;
         rsp_sid_ff   <= e_sid;
         rsp_slot_ff  <= e_slot;
         rsp_from_ff  <= e_from;
         rsp_to_ff    <= e_to;
         rsp_speed_ff <= e_speed;
         rsp_last_ff  <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_speed_ff, rsp_to_ff, rsp_from_ff,
                        rsp_slot_ff, rsp_sid_ff, rsp_owner_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PARTS))
      else $error("part count above table depth");

   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (count_ff != '0) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("walk index beyond loaded parts");

   a_query_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_query |=> (state_ff == ST_SCAN) && (idx_ff == '0))
      else $error("query did not start a walk at entry zero");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      emit_go && e_last |=> (state_ff == ST_IDLE))
      else $error("walk went on after its final result");

   a_empty_route_origin: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (running_ff == '0))
      else $error("running start set on an empty table");

endmodule
`default_nettype wire
